/* rtl/multi_voice_sample_mixer_top_assert.svh */
// Assertion macros for the sample mixer controller.
// Depends on nothing; included by modules that carry assertions.
`ifndef MULTI_VOICE_SAMPLE_MIXER_TOP_ASSERT_SVH
`define MULTI_VOICE_SAMPLE_MIXER_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define MVSM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define MVSM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

/* rtl/mvsm_pkg.sv */
// Package for the sample mixer: constants, controller command struct and a gain clamp helper.
// Depends on nothing.
package mvsm_pkg;
	localparam int NUM_VOICES_DEF    = 8;
	localparam int VOICE_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF   = 16;
	localparam logic [15:0] GAIN_ONE = 16'h8000;

	localparam logic [1:0] FUNC_BEGIN = 2'd0;
	localparam logic [1:0] FUNC_LOAD  = 2'd1;
	localparam logic [1:0] FUNC_STOP  = 2'd2;
	localparam logic [1:0] FUNC_MIX   = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_IDLE = 2'd1;
	localparam logic [1:0] ST_NO_LOAD = 2'd2;
	localparam logic [1:0] ST_FULL    = 2'd3;

	localparam logic REG_STREAM_GAIN = 1'b0;
	localparam logic REG_EFFECT_GAIN = 1'b1;

	// Commands from controller to datapath.
	typedef struct packed {
		logic start;     // capture item and run its bookkeeping
		logic mix_clr;   // marks an accepted mix item (unused by the datapath)
		logic rd;        // issue memory read for the current voice
		logic mac;       // multiply-accumulate returned sample
		logic fin;       // round, saturate and latch result
	} mvsm_cmd_t;

	function automatic logic [15:0] clamp_gain(input logic [15:0] g);
		clamp_gain = (g > GAIN_ONE) ? GAIN_ONE : g;
	endfunction
endpackage

/* rtl/multi_voice_sample_mixer_top.sv */
// Sample mixer: a begin, load or stop item goes from acceptance straight to the done state,
// which loads the result register, and the next item is taken once the block is idle again;
// a mix item walks one voice per cycle through the single memory read port and multiplier,
// then passes the drain, finish and done states before its result is valid.
// A stalled result holds the block. Reset clears voices, gains to 1.0, loading to none and
// the underrun count; voice memory is not cleared. Depends on mvsm_pkg, mvsm_ctrl and mvsm_dp.
module multi_voice_sample_mixer_top #(
	parameter int NUM_VOICES    = mvsm_pkg::NUM_VOICES_DEF,
	parameter int VOICE_SAMPLES = mvsm_pkg::VOICE_SAMPLES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         func,
	input  logic [15:0]        voice_gain,
	input  logic signed [15:0] sample_value,
	input  logic               last_flag,
	input  logic               stream_present,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] mixed_sample,
	output logic [3:0]         active_voices,
	output logic [31:0]        underrun_total,
	output logic [2:0]         voice_slot,
	output logic [1:0]         status,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data
);
	mvsm_pkg::mvsm_cmd_t cmd;
	logic [$clog2(NUM_VOICES+1)-1:0] vidx;
	logic res_load;

	assign cfg_ready = 1'b1;

	mvsm_ctrl #(.NUM_VOICES(NUM_VOICES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_func(func),
		.in_stall(in_stall), .out_busy(out_valid && out_stall),
		.res_load(res_load), .cmd(cmd), .vidx(vidx)
	);

	mvsm_dp #(
		.NUM_VOICES(NUM_VOICES), .VOICE_SAMPLES(VOICE_SAMPLES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .vidx(vidx), .res_load(res_load),
		.cfg_we(cfg_valid), .cfg_idx(cfg_index), .cfg_data(cfg_data),
		.func(func), .voice_gain(voice_gain), .sample_value(sample_value),
		.last_flag(last_flag), .stream_present(stream_present),
		.out_valid(out_valid), .out_stall(out_stall),
		.mixed_sample(mixed_sample), .active_voices(active_voices),
		.underrun_total(underrun_total), .voice_slot(voice_slot), .status(status)
	);
endmodule

/* rtl/mvsm_ram.sv */
// Generic single-port RAM with registered read.
// Depends on nothing.
module mvsm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32768
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one read per cycle at the same address; the read returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

/* rtl/mvsm_ctrl.sv */
// Controller for the sample mixer: walks voices one per cycle for a mix item.
// Depends on mvsm_pkg and multi_voice_sample_mixer_top_assert.svh.
`include "multi_voice_sample_mixer_top_assert.svh"
module mvsm_ctrl #(
	parameter int NUM_VOICES = mvsm_pkg::NUM_VOICES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic [1:0]            in_func,
	output logic                  in_stall,
	input  logic                  out_busy,
	output logic                  res_load,
	output mvsm_pkg::mvsm_cmd_t   cmd,
	output logic [$clog2(NUM_VOICES+1)-1:0] vidx
);
	localparam int VW = $clog2(NUM_VOICES+1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_WALK = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_FIN = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]    state_q;
	logic [VW-1:0] vidx_q;
	logic          accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && !in_stall;
	assign vidx = vidx_q;

	// Command decode.
	always_comb begin
		cmd = '0;
		res_load = 1'b0;
		cmd.start = accept;
		cmd.mix_clr = accept && (in_func == mvsm_pkg::FUNC_MIX);
		cmd.rd = (state_q == S_WALK);
		cmd.mac = (state_q == S_WALK && vidx_q != '0) || (state_q == S_DRAIN);
		cmd.fin = (state_q == S_FIN);
		res_load = (state_q == S_DONE) && !out_busy;
	end

	// State sequence: walk issues reads, MAC follows each read in the cycle after it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vidx_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					vidx_q <= '0;
					if (accept) begin
						state_q <= (in_func == mvsm_pkg::FUNC_MIX) ? S_WALK : S_DONE;
					end
				end
				S_WALK: begin
					vidx_q <= vidx_q + 1'b1;
					if (vidx_q == VW'(NUM_VOICES - 1)) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_FIN;
				S_FIN: state_q <= S_DONE;
				S_DONE: begin
					if (!out_busy) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`MVSM_ASSERT_IMP(a_no_acc_busy, clk, arst_n, state_q != S_IDLE, in_stall)
	`MVSM_ASSERT_NEXT(a_fin_done, clk, arst_n, cmd.fin, state_q == S_DONE)
	`MVSM_ASSERT_IMP(a_rd_range, clk, arst_n, cmd.rd, vidx_q < VW'(NUM_VOICES))
endmodule

/* rtl/mvsm_dp.sv */
// Datapath for the sample mixer: voice table, memory, accumulator and result.
// Depends on mvsm_pkg and mvsm_ram.
module mvsm_dp #(
	parameter int NUM_VOICES    = mvsm_pkg::NUM_VOICES_DEF,
	parameter int VOICE_SAMPLES = mvsm_pkg::VOICE_SAMPLES_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mvsm_pkg::mvsm_cmd_t cmd,
	input  logic [$clog2(NUM_VOICES+1)-1:0] vidx,
	input  logic                res_load,
	input  logic                cfg_we,
	input  logic                cfg_idx,
	input  logic [15:0]         cfg_data,
	input  logic [1:0]          func,
	input  logic [15:0]         voice_gain,
	input  logic signed [15:0]  sample_value,
	input  logic                last_flag,
	input  logic                stream_present,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  mixed_sample,
	output logic [3:0]          active_voices,
	output logic [31:0]         underrun_total,
	output logic [2:0]          voice_slot,
	output logic [1:0]          status
);
	localparam int VW = $clog2(NUM_VOICES+1);
	localparam int SW = $clog2(NUM_VOICES);
	localparam int LW = $clog2(VOICE_SAMPLES+1);
	localparam int CW = $clog2(VOICE_SAMPLES);
	localparam int AW = $clog2(NUM_VOICES*VOICE_SAMPLES);
	localparam int ACCW = 16 + 16 + VW + 2;
	localparam logic signed [ACCW-1:0] SAT_HI =
		ACCW'((64'sd1 <<< (mvsm_pkg::SAMPLE_BITS_DEF-1)) - 1);
	localparam logic signed [ACCW-1:0] SAT_LO =
		-ACCW'(64'sd1 <<< (mvsm_pkg::SAMPLE_BITS_DEF-1));
	localparam int SW1 = (SW > 0) ? SW : 1;

	logic [15:0] stream_gain_q, effect_gain_q;
	logic [NUM_VOICES-1:0] active_q;
	logic [LW-1:0] cursor_q [NUM_VOICES];
	logic [LW-1:0] length_q [NUM_VOICES];
	logic [15:0]   level_q [NUM_VOICES];
	logic [VW-1:0] loading_q;
	logic [31:0]   under_q;
	logic          short_q;

	logic        last_q;
	logic signed [ACCW-1:0] acc_q;
	logic [3:0]  nact_q;
	logic [2:0]  slot_q;
	logic [1:0]  stat_q;
	logic signed [15:0] mix_q;

	logic        mac_v_q;
	logic [15:0] g_s1;

	logic [VW-1:0] idle_v;
	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [15:0]   ram_rdata;
	logic [SW1-1:0] cur_v, ld_v;
	logic [31:0]   gprod;
	logic signed [ACCW-1:0] rnd;

	// Lowest idle voice.
	always_comb begin
		idle_v = VW'(NUM_VOICES);
		for (int i = NUM_VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				idle_v = VW'(i);
			end
		end
	end

	assign cur_v = SW1'(vidx);
	assign ld_v = SW1'(loading_q);
	assign gprod = level_q[cur_v] * effect_gain_q;

	// Memory port: load writes, walk reads.
	always_comb begin
		ram_we = 1'b0;
		ram_addr = AW'(cur_v) * AW'(VOICE_SAMPLES) + AW'(cursor_q[cur_v][CW-1:0]);
		if (cmd.start && func == mvsm_pkg::FUNC_LOAD && loading_q < VW'(NUM_VOICES)
				&& length_q[ld_v] < LW'(VOICE_SAMPLES)) begin
			ram_we = 1'b1;
			ram_addr = AW'(ld_v) * AW'(VOICE_SAMPLES) + AW'(length_q[ld_v][CW-1:0]);
		end
	end

	mvsm_ram #(.WIDTH(16), .DEPTH(NUM_VOICES*VOICE_SAMPLES)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr),
		.wdata(sample_value), .rdata(ram_rdata)
	);

	assign rnd = (acc_q + ACCW'(32'sd16384)) >>> 15;

	// Gain registers, control state of voices, item bookkeeping and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stream_gain_q <= mvsm_pkg::GAIN_ONE;
			effect_gain_q <= mvsm_pkg::GAIN_ONE;
			active_q <= '0;
			loading_q <= VW'(NUM_VOICES);
			under_q <= '0;
			short_q <= 1'b0;
			mac_v_q <= 1'b0;
			out_valid <= 1'b0;
			for (int i = 0; i < NUM_VOICES; i++) begin
				cursor_q[i] <= '0;
				length_q[i] <= '0;
				level_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_idx == mvsm_pkg::REG_STREAM_GAIN) begin
					stream_gain_q <= mvsm_pkg::clamp_gain(cfg_data);
				end else begin
					effect_gain_q <= mvsm_pkg::clamp_gain(cfg_data);
				end
			end
			if (cmd.start) begin
				last_q <= last_flag;
				nact_q <= '0;
				slot_q <= '0;
				stat_q <= mvsm_pkg::ST_OK;
				mix_q <= '0;
				unique case (func)
					mvsm_pkg::FUNC_BEGIN: begin
						if (idle_v < VW'(NUM_VOICES)) begin
							level_q[SW1'(idle_v)] <= mvsm_pkg::clamp_gain(voice_gain);
							cursor_q[SW1'(idle_v)] <= '0;
							length_q[SW1'(idle_v)] <= '0;
							loading_q <= idle_v;
							slot_q <= 3'(idle_v);
						end else begin
							stat_q <= mvsm_pkg::ST_NO_IDLE;
						end
					end
					mvsm_pkg::FUNC_LOAD: begin
						if (loading_q >= VW'(NUM_VOICES)) begin
							stat_q <= mvsm_pkg::ST_NO_LOAD;
						end else begin
							slot_q <= 3'(loading_q);
							if (length_q[ld_v] >= LW'(VOICE_SAMPLES)) begin
								stat_q <= mvsm_pkg::ST_FULL;
							end else begin
								length_q[ld_v] <= length_q[ld_v] + 1'b1;
							end
							if (last_flag) begin
								active_q[ld_v] <= 1'b1;
								cursor_q[ld_v] <= '0;
								loading_q <= VW'(NUM_VOICES);
							end
						end
					end
					mvsm_pkg::FUNC_STOP: begin
						active_q <= '0;
						loading_q <= VW'(NUM_VOICES);
					end
					mvsm_pkg::FUNC_MIX: begin
						acc_q <= stream_present
							? ACCW'(sample_value * $signed({1'b0, stream_gain_q})) : '0;
						if (!stream_present) begin
							short_q <= 1'b1;
						end
					end
					default: ;
				endcase
			end
			// Read stage: capture gain and retire voice as cursor moves.
			mac_v_q <= cmd.rd && active_q[cur_v];
			if (cmd.rd) begin
				g_s1 <= gprod[30:15];
				if (active_q[cur_v]) begin
					nact_q <= nact_q + 1'b1;
					cursor_q[cur_v] <= cursor_q[cur_v] + 1'b1;
					if (cursor_q[cur_v] + 1'b1 >= length_q[cur_v]) begin
						active_q[cur_v] <= 1'b0;
					end
				end
			end
			if (cmd.mac && mac_v_q) begin
				acc_q <= acc_q + ACCW'($signed(ram_rdata) * $signed({1'b0, g_s1}));
			end
			if (cmd.fin) begin
				if (rnd > SAT_HI) begin
					mix_q <= 16'(SAT_HI);
				end else if (rnd < SAT_LO) begin
					mix_q <= 16'(SAT_LO);
				end else begin
					mix_q <= 16'(rnd);
				end
				if (last_q) begin
					if (short_q) begin
						under_q <= under_q + 1'b1;
					end
					short_q <= 1'b0;
				end
			end
			// Output register.
			if (res_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res_load) begin
			mixed_sample <= mix_q;
			active_voices <= nact_q;
			underrun_total <= under_q;
			voice_slot <= slot_q;
			status <= stat_q;
		end
	end
endmodule
